[design/sqv_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the sprite quad vertex generator.
package sqv_pkg;

    localparam int TRIG_TABLE_DEPTH = 256;
    localparam int IDX_W            = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int IDX_PROD_W       = 14 + $clog2(TRIG_TABLE_DEPTH) + 1;
    localparam int SHADE_W          = 50;
    localparam longint HALF_PI_Q30  = 64'd1686629713;
    localparam int ONE_Q15          = 32768;

    localparam logic [1:0] CORNER_LT = 2'd0;
    localparam logic [1:0] CORNER_RT = 2'd1;
    localparam logic [1:0] CORNER_RB = 2'd2;
    localparam logic [1:0] CORNER_LB = 2'd3;

    localparam int FLIP_X_BIT = 0;
    localparam int FLIP_Y_BIT = 1;

    typedef logic [15:0] sine_tab_t [TRIG_TABLE_DEPTH + 1];

    // sin(k*pi/(2*DEPTH)) in Q1.15 from a truncated Q2.30 Taylor series
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   t;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k <= TRIG_TABLE_DEPTH; k++)
        begin
            x    = (64'(k) * 64'(HALF_PI_Q30)) / TRIG_TABLE_DEPTH;
            term = x;
            sum  = 0;
            for (int n = 1; n <= 10; n++)
            begin
                if (term != 64'd0)
                begin
                    if ((n % 2) == 1)
                        sum = sum + longint'(term);
                    else
                        sum = sum - longint'(term);
                    term = (term * x) >> 30;
                    term = (term * x) >> 30;
                    term = term / 64'((2 * n) * (2 * n + 1));
                end
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + (64'sd1 <<< 14)) >>> 15;
            if (sum > ONE_Q15)
                sum = ONE_Q15;
            t[k] = 16'(sum);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[design/sqv_sprite_if.sv]
// Handshake channels: sprite draw transactions in, vertex transactions out.
interface sqv_sprite_if
    import sqv_pkg::*;
();
    logic               valid;
    logic               ready;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic [31:0]        pivot_pair;
    logic [15:0]        turn_angle;
    logic [31:0]        u_pair;
    logic [31:0]        v_pair;
    logic [1:0]         flip_mode;
    logic [SHADE_W-1:0] shade_attrs;
    logic [31:0]        rgba_color;
    logic               last_item;

    modport source (output valid, rect_x, rect_y, rect_w, rect_h, pivot_pair, turn_angle,
                    u_pair, v_pair, flip_mode, shade_attrs, rgba_color, last_item,
                    input ready);
    modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, pivot_pair, turn_angle,
                    u_pair, v_pair, flip_mode, shade_attrs, rgba_color, last_item,
                    output ready);
endinterface

interface sqv_vertex_if
    import sqv_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         corner;
    logic               last_corner;
    logic               end_of_batch;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [SHADE_W-1:0] shade_out;
    logic [31:0]        color_out;

    modport source (output valid, corner, last_corner, end_of_batch, pos_x, pos_y, tex_u,
                    tex_v, shade_out, color_out, input ready);
    modport sink   (input valid, corner, last_corner, end_of_batch, pos_x, pos_y, tex_u,
                    tex_v, shade_out, color_out, output ready);
endinterface

[design/sprite_quad_vertex_gen.sv]
// Sprite quad vertex generator: four rotated, textured corners per sprite transaction.
// Each sprite is held in a hold register while the corner sequencer issues its four corners in turn.
// One vertex per cycle while the output is not stalled; the next sprite is taken as the last corner issues.
// Four register stages plus the output register advance together; a stall holds them all.
// Reset clears the hold valid bit, the corner counter and all stage valid bits.
// The sine table is constant logic and needs no fill after reset.
module sprite_quad_vertex_gen
    import sqv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sqv_sprite_if.sink    sprite,
    sqv_vertex_if.source  vertex
);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [31:0]        pivot;
        logic [15:0]        ang;
        logic [31:0]        u;
        logic [31:0]        v;
        logic [1:0]         flip;
        logic [SHADE_W-1:0] shade;
        logic [31:0]        color;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [1:0]         k;
        logic               last;
        logic [15:0]        tu;
        logic [15:0]        tv;
        logic [SHADE_W-1:0] shade;
        logic [31:0]        color;
    } side_t;

    typedef struct packed {
        side_t              sd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [15:0]        pfx;
        logic [15:0]        pfy;
        logic signed [16:0] sn;
        logic signed [16:0] cs;
    } s1_t;

    typedef struct packed {
        side_t              sd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [30:0]        pxw;
        logic [30:0]        pyh;
        logic signed [16:0] sn;
        logic signed [16:0] cs;
    } s2_t;

    typedef struct packed {
        side_t              sd;
        logic signed [48:0] bx;
        logic signed [48:0] by;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [16:0] sn;
        logic signed [16:0] cs;
    } s3_t;

    typedef struct packed {
        side_t              sd;
        logic signed [48:0] bx;
        logic signed [48:0] by;
        logic signed [49:0] dxc;
        logic signed [49:0] dys;
        logic signed [49:0] dxs;
        logic signed [49:0] dyc;
    } s4_t;

    item_t      hold_reg;
    logic       hold_v_reg;
    logic [1:0] cnt_reg;
    s1_t        s1_reg, s1_next;
    s2_t        s2_reg, s2_next;
    s3_t        s3_reg, s3_next;
    s4_t        s4_reg, s4_next;
    logic       s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    side_t      out_sd_reg;
    logic signed [15:0] out_x_reg, out_y_reg, out_x_next, out_y_next;

    logic       advance;
    logic       issue;
    logic       take;

    assign advance      = !out_v_reg || vertex.ready;
    assign issue        = advance && hold_v_reg;
    assign sprite.ready = !hold_v_reg || (issue && (cnt_reg == CORNER_LB));
    assign take         = sprite.valid && sprite.ready;

    // corner sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            cnt_reg    <= CORNER_LT;
        end
        else
        begin
            if (take)
                hold_v_reg <= 1'b1;
            else if (issue && (cnt_reg == CORNER_LB))
                hold_v_reg <= 1'b0;
            if (issue)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg.x     <= sprite.rect_x;
            hold_reg.y     <= sprite.rect_y;
            hold_reg.w     <= sprite.rect_w;
            hold_reg.h     <= sprite.rect_h;
            hold_reg.pivot <= sprite.pivot_pair;
            hold_reg.ang   <= sprite.turn_angle;
            hold_reg.u     <= sprite.u_pair;
            hold_reg.v     <= sprite.v_pair;
            hold_reg.flip  <= sprite.flip_mode;
            hold_reg.shade <= sprite.shade_attrs;
            hold_reg.color <= sprite.rgba_color;
            hold_reg.last  <= sprite.last_item;
        end
    end

    // stage 1: trig lookup, pivot clamp, texture flip
    always_comb
    begin
        logic [IDX_PROD_W-1:0] prod;
        logic [IDX_PROD_W-1:0] shifted;
        logic [IDX_W-1:0]      idx;
        logic signed [16:0]    a;
        logic signed [16:0]    b;
        logic                  right;
        logic                  bottom;
        prod    = IDX_PROD_W'(hold_reg.ang[13:0]) * IDX_PROD_W'(TRIG_TABLE_DEPTH)
                  + IDX_PROD_W'(8192);
        shifted = prod >> 14;
        if (shifted > IDX_PROD_W'(TRIG_TABLE_DEPTH))
            idx = IDX_W'(TRIG_TABLE_DEPTH);
        else
            idx = shifted[IDX_W-1:0];
        a = signed'({1'b0, SINE_TAB[idx]});
        b = signed'({1'b0, SINE_TAB[IDX_W'(TRIG_TABLE_DEPTH) - idx]});
        case (hold_reg.ang[15:14])
            2'd0:
            begin
                s1_next.sn = a;
                s1_next.cs = b;
            end
            2'd1:
            begin
                s1_next.sn = b;
                s1_next.cs = -a;
            end
            2'd2:
            begin
                s1_next.sn = -a;
                s1_next.cs = -b;
            end
            default:
            begin
                s1_next.sn = -b;
                s1_next.cs = a;
            end
        endcase
        right  = (cnt_reg == CORNER_RT) || (cnt_reg == CORNER_RB);
        bottom = (cnt_reg == CORNER_RB) || (cnt_reg == CORNER_LB);
        s1_next.x   = hold_reg.x;
        s1_next.y   = hold_reg.y;
        s1_next.w   = hold_reg.w;
        s1_next.h   = hold_reg.h;
        s1_next.pfx = (hold_reg.pivot[15:0] > 16'(ONE_Q15)) ? 16'(ONE_Q15)
                                                             : hold_reg.pivot[15:0];
        s1_next.pfy = (hold_reg.pivot[31:16] > 16'(ONE_Q15)) ? 16'(ONE_Q15)
                                                              : hold_reg.pivot[31:16];
        s1_next.sd.k     = cnt_reg;
        s1_next.sd.last  = hold_reg.last && (cnt_reg == CORNER_LB);
        s1_next.sd.tu    = (right ^ hold_reg.flip[FLIP_X_BIT]) ? hold_reg.u[31:16]
                                                                : hold_reg.u[15:0];
        s1_next.sd.tv    = (bottom ^ hold_reg.flip[FLIP_Y_BIT]) ? hold_reg.v[31:16]
                                                                 : hold_reg.v[15:0];
        s1_next.sd.shade = hold_reg.shade;
        s1_next.sd.color = hold_reg.color;
    end

    // stage 2: pivot offsets
    always_comb
    begin
        s2_next.sd  = s1_reg.sd;
        s2_next.x   = s1_reg.x;
        s2_next.y   = s1_reg.y;
        s2_next.w   = s1_reg.w;
        s2_next.h   = s1_reg.h;
        s2_next.pxw = 31'(s1_reg.pfx) * 31'(s1_reg.w);
        s2_next.pyh = 31'(s1_reg.pfy) * 31'(s1_reg.h);
        s2_next.sn  = s1_reg.sn;
        s2_next.cs  = s1_reg.cs;
    end

    // stage 3: pivot base and corner deltas
    always_comb
    begin
        logic signed [33:0] cx0;
        logic signed [33:0] cy0;
        logic               right;
        logic               bottom;
        right  = (s2_reg.sd.k == CORNER_RT) || (s2_reg.sd.k == CORNER_RB);
        bottom = (s2_reg.sd.k == CORNER_RB) || (s2_reg.sd.k == CORNER_LB);
        cx0 = (34'(s2_reg.x) <<< 15) + signed'({3'b000, s2_reg.pxw});
        cy0 = (34'(s2_reg.y) <<< 15) + signed'({3'b000, s2_reg.pyh});
        s3_next.sd = s2_reg.sd;
        s3_next.bx = 49'(cx0) <<< 15;
        s3_next.by = 49'(cy0) <<< 15;
        s3_next.dx = (right ? signed'({3'b000, s2_reg.w, 15'd0}) : 33'sd0)
                     - signed'({2'b00, s2_reg.pxw});
        s3_next.dy = (bottom ? signed'({3'b000, s2_reg.h, 15'd0}) : 33'sd0)
                     - signed'({2'b00, s2_reg.pyh});
        s3_next.sn = s2_reg.sn;
        s3_next.cs = s2_reg.cs;
    end

    // stage 4: rotation products
    always_comb
    begin
        s4_next.sd  = s3_reg.sd;
        s4_next.bx  = s3_reg.bx;
        s4_next.by  = s3_reg.by;
        s4_next.dxc = 50'(s3_reg.dx) * 50'(s3_reg.cs);
        s4_next.dys = 50'(s3_reg.dy) * 50'(s3_reg.sn);
        s4_next.dxs = 50'(s3_reg.dx) * 50'(s3_reg.sn);
        s4_next.dyc = 50'(s3_reg.dy) * 50'(s3_reg.cs);
    end

    // stage 5: sum, round half up, saturate
    always_comb
    begin
        logic signed [51:0] rx;
        logic signed [51:0] ry;
        logic signed [21:0] qx;
        logic signed [21:0] qy;
        rx = 52'(s4_reg.bx) + 52'(s4_reg.dxc) - 52'(s4_reg.dys) + 52'sd536870912;
        ry = 52'(s4_reg.by) + 52'(s4_reg.dxs) + 52'(s4_reg.dyc) + 52'sd536870912;
        qx = 22'(rx >>> 30);
        qy = 22'(ry >>> 30);
        if (qx > 22'sd32767)
            out_x_next = 16'sh7FFF;
        else if (qx < -22'sd32768)
            out_x_next = -16'sh8000;
        else
            out_x_next = 16'(qx);
        if (qy > 22'sd32767)
            out_y_next = 16'sh7FFF;
        else if (qy < -22'sd32768)
            out_y_next = -16'sh8000;
        else
            out_y_next = 16'(qy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg  <= hold_v_reg;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            out_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s4_reg     <= s4_next;
            out_sd_reg <= s4_reg.sd;
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
        end
    end

    assign vertex.valid        = out_v_reg;
    assign vertex.corner       = out_sd_reg.k;
    assign vertex.last_corner  = (out_sd_reg.k == CORNER_LB);
    assign vertex.end_of_batch = out_sd_reg.last;
    assign vertex.pos_x        = out_x_reg;
    assign vertex.pos_y        = out_y_reg;
    assign vertex.tex_u        = out_sd_reg.tu;
    assign vertex.tex_v        = out_sd_reg.tv;
    assign vertex.shade_out    = out_sd_reg.shade;
    assign vertex.color_out    = out_sd_reg.color;

endmodule

[design/sqv_checker.sv]
// Port-level checks of the sprite quad vertex generator, bound to the top level.
module sqv_checker
    import sqv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               vld,
    input logic               rdy,
    input logic [1:0]         corner,
    input logic               last_corner,
    input logic               end_of_batch,
    input logic signed [15:0] pos_x
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        vld && !rdy |=> vld)
        else $error("vertex valid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        vld && !rdy |=> $stable(corner) && $stable(pos_x))
        else $error("vertex payload changed under stall");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        vld |-> (last_corner == (corner == CORNER_LB)))
        else $error("last_corner does not match corner");

    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        vld && end_of_batch |-> last_corner)
        else $error("end_of_batch off the fourth corner");

endmodule

bind sprite_quad_vertex_gen sqv_checker u_sqv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .vld          (vertex.valid),
    .rdy          (vertex.ready),
    .corner       (vertex.corner),
    .last_corner  (vertex.last_corner),
    .end_of_batch (vertex.end_of_batch),
    .pos_x        (vertex.pos_x)
);

[bench/tb_sprite_quad_vertex_gen.sv]
// Self-checking bench for the sprite quad vertex generator: random sprites, corner scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
    logic [1:0]         corner;
    logic               last_corner;
    logic               end_of_batch;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [49:0]        shade_out;
    logic [31:0]        color_out;
} vertex_t;

typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic [31:0]        pivot_pair;
    logic [15:0]        turn_angle;
    logic [31:0]        u_pair;
    logic [31:0]        v_pair;
    logic [1:0]         flip_mode;
    logic [49:0]        shade_attrs;
    logic [31:0]        rgba_color;
    logic               last_item;
} sprite_t;

class quad_scoreboard;
    vertex_t corners_due[$];
    longint  sine_q15[0:256];
    int      errors;
    int      sprites_seen;
    int      vertices_seen;

    function new();
        longint x, term, sum;
        errors = 0;
        sprites_seen = 0;
        vertices_seen = 0;
        for (int k = 0; k <= 256; k++)
        begin
            x = (longint'(k) * 64'd1686629713) / 256;
            term = x;
            sum = 0;
            for (int n = 1; n <= 10 && term != 0; n++)
            begin
                if (n % 2 == 1)
                    sum += term;
                else
                    sum -= term;
                term = (term * x) >>> 30;
                term = (term * x) >>> 30;
                term = term / ((2 * n) * (2 * n + 1));
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + (64'sd1 <<< 14)) >>> 15;
            if (sum > 32768)
                sum = 32768;
            sine_q15[k] = sum;
        end
    endfunction

    function automatic logic [15:0] round_clip(longint v);
        longint q;
        v += 64'sd1 <<< 29;
        if (v >= 0)
            q = v / (64'sd1 <<< 30);
        else
            q = -((-v + (64'sd1 <<< 30) - 1) / (64'sd1 <<< 30));
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function void note_sprite(sprite_t s);
        longint x, y, w, h, pfx, pfy, pxw, pyh, cx0, cy0, a, b, sn, cs, dx, dy;
        int unsigned idx;
        logic right, bottom;
        vertex_t v;
        x = s.rect_x;
        y = s.rect_y;
        w = s.rect_w;
        h = s.rect_h;
        pfx = (s.pivot_pair[15:0] > 32768) ? 32768 : s.pivot_pair[15:0];
        pfy = (s.pivot_pair[31:16] > 32768) ? 32768 : s.pivot_pair[31:16];
        pxw = pfx * w;
        pyh = pfy * h;
        cx0 = x * 32768 + pxw;
        cy0 = y * 32768 + pyh;
        idx = (int'(s.turn_angle[13:0]) * 256 + 8192) >> 14;
        if (idx > 256)
            idx = 256;
        a = sine_q15[idx];
        b = sine_q15[256 - idx];
        case (s.turn_angle[15:14])
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
        sprites_seen++;
        for (int k = 0; k < 4; k++)
        begin
            right = (k == 1 || k == 2);
            bottom = (k >= 2);
            dx = (right ? w * 32768 : 0) - pxw;
            dy = (bottom ? h * 32768 : 0) - pyh;
            v.corner = k[1:0];
            v.last_corner = (k == 3);
            v.end_of_batch = (k == 3) && s.last_item;
            v.pos_x = round_clip(cx0 * 32768 + dx * cs - dy * sn);
            v.pos_y = round_clip(cy0 * 32768 + dx * sn + dy * cs);
            v.tex_u = (right ^ s.flip_mode[sqv_pkg::FLIP_X_BIT]) ? s.u_pair[31:16]
                                                                : s.u_pair[15:0];
            v.tex_v = (bottom ^ s.flip_mode[sqv_pkg::FLIP_Y_BIT]) ? s.v_pair[31:16]
                                                                 : s.v_pair[15:0];
            v.shade_out = s.shade_attrs;
            v.color_out = s.rgba_color;
            corners_due.push_back(v);
        end
    endfunction

    function void check_vertex(vertex_t got);
        vertex_t e;
        vertices_seen++;
        if (corners_due.size() == 0)
        begin
            errors++;
            $display("%0t unexpected vertex: expected none, actual %h", $time, got);
            return;
        end
        e = corners_due.pop_front();
        if (got.corner !== e.corner)
            report("corner", e.corner, got.corner);
        if (got.last_corner !== e.last_corner)
            report("last_corner", e.last_corner, got.last_corner);
        if (got.end_of_batch !== e.end_of_batch)
            report("end_of_batch", e.end_of_batch, got.end_of_batch);
        if (got.pos_x !== e.pos_x)
            report("pos_x", e.pos_x, got.pos_x);
        if (got.pos_y !== e.pos_y)
            report("pos_y", e.pos_y, got.pos_y);
        if (got.tex_u !== e.tex_u)
            report("tex_u", e.tex_u, got.tex_u);
        if (got.tex_v !== e.tex_v)
            report("tex_v", e.tex_v, got.tex_v);
        if (got.shade_out !== e.shade_out)
            report("shade_out", e.shade_out, got.shade_out);
        if (got.color_out !== e.color_out)
            report("color_out", e.color_out, got.color_out);
    endfunction

    function void report(string field, logic [63:0] e, logic [63:0] a);
        errors++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, field, e, a);
    endfunction
endclass

module tb;
    import sqv_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    sqv_sprite_if sprite ();
    sqv_vertex_if vertex ();

    quad_scoreboard board;
    sprite_t sprites_queued[$];
    bit      no_idle = 1'b0;
    bit      hold_off = 1'b0;
    bit      stim_done = 1'b0;

    sprite_quad_vertex_gen dut (.clk(clk), .rst_n(rst_n), .sprite(sprite), .vertex(vertex));

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        sprite.valid = 1'b0;
        {sprite.rect_x, sprite.rect_y, sprite.rect_w, sprite.rect_h, sprite.pivot_pair,
         sprite.turn_angle, sprite.u_pair, sprite.v_pair, sprite.flip_mode,
         sprite.shade_attrs, sprite.rgba_color, sprite.last_item} = '0;
        vertex.ready = 1'b0;
    end

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic sprite_t rand_sprite();
        sprite_t s;
        s.rect_x = 16'($urandom);
        s.rect_y = 16'($urandom);
        s.rect_w = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 4096));
        s.rect_h = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 4096));
        if ($urandom_range(0, 9) == 0)
            s.rect_w = 15'd0;
        s.pivot_pair = {rand_frac(), rand_frac()};
        s.turn_angle = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 3) << 14)
                                                  : 16'($urandom);
        s.u_pair = $urandom;
        s.v_pair = $urandom;
        s.flip_mode = 2'($urandom);
        s.shade_attrs = {18'($urandom), 32'($urandom)};
        s.rgba_color = $urandom;
        s.last_item = ($urandom_range(0, 3) == 0);
        return s;
    endfunction

    task automatic send_sprite(sprite_t s);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            sprite.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sprite.valid <= 1'b1;
        {sprite.rect_x, sprite.rect_y, sprite.rect_w, sprite.rect_h, sprite.pivot_pair,
         sprite.turn_angle, sprite.u_pair, sprite.v_pair, sprite.flip_mode,
         sprite.shade_attrs, sprite.rgba_color, sprite.last_item} <= s;
        do
            @(posedge clk);
        while (!sprite.ready);
        board.note_sprite(s);
        @(negedge clk);
    endtask

    always @(posedge clk)
        if (rst_n && vertex.valid && vertex.ready)
            board.check_vertex({vertex.corner, vertex.last_corner, vertex.end_of_batch,
                                vertex.pos_x, vertex.pos_y, vertex.tex_u, vertex.tex_v,
                                vertex.shade_out, vertex.color_out});

    initial
    begin : sink_side
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                vertex.ready <= 1'b0;
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                vertex.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                vertex.ready <= 1'b1;
        end
    end

    initial
    begin : stall_window
        @(posedge rst_n);
        repeat (300) @(negedge clk);
        hold_off = 1'b1;
        repeat (120) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : stimulus
        sprite_t s;
        int wait_cycles;
        board = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int d = 0; d < 22; d++)
        begin
            s = rand_sprite();
            case (d)
                0: begin s.rect_x = 16'sh7fff; s.rect_y = 16'sh7fff;
                         s.rect_w = 15'h7fff; s.rect_h = 15'h7fff; s.turn_angle = 16'd0; end
                1: begin s.rect_x = 16'sh8000; s.rect_y = 16'sh8000;
                         s.rect_w = 15'h7fff; s.rect_h = 15'h7fff;
                         s.turn_angle = 16'h8000; end
                2: begin s.rect_w = 15'd0; s.rect_h = 15'd0; end
                3: s.pivot_pair = 32'hffff_ffff;
                4: s.pivot_pair = 32'h8000_8000;
                5: s.pivot_pair = 32'h0;
                6: s.turn_angle = 16'h4000;
                7: s.turn_angle = 16'hc000;
                8: s.turn_angle = 16'hffff;
                9: s.turn_angle = 16'h3fff;
                10: s.u_pair = 32'hffff_ffff;
                11: begin s.v_pair = 32'h0; s.u_pair = 32'h0; end
                12: begin s.shade_attrs = '1; s.rgba_color = '1; end
                13: begin s.shade_attrs = '0; s.rgba_color = '0; end
                default: ;
            endcase
            if (d >= 14 && d < 18)
                s.flip_mode = 2'(d - 14);
            s.last_item = d[0];
            send_sprite(s);
        end
        for (int r = 0; r < 158; r++)
        begin
            if (r == 130)
                no_idle = 1'b1;
            send_sprite(rand_sprite());
        end
        sprite.valid <= 1'b0;
        wait_cycles = 0;
        while (board.corners_due.size() != 0 && wait_cycles < 20000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (12) @(negedge clk);
        $display("Checked %0d sprites and %0d vertices: extremes, flips, quadrants, pivots.",
                 board.sprites_seen, board.vertices_seen);
        if (board.errors == 0 && board.corners_due.size() == 0)
            $display("[sprite_quad_vertex_gen] OK");
        else
            $display("[sprite_quad_vertex_gen] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("[sprite_quad_vertex_gen] ERROR");
        $finish;
    end
endmodule
